// File: rtl/bdhm_pkg.sv
`default_nettype none

package bdhm_pkg;

   localparam int unsigned CountWidth   = 16;
   localparam int unsigned ClickWidth   = 11;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxWidth-1:0] CsrActiveLow  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrDebounceMs = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrHoldMs     = 2'd2;

   // Register values after reset.
   localparam logic                  ActiveLowReset  = 1'b1;
   localparam logic [CountWidth-1:0] DebounceMsReset = 16'd20;
   localparam logic [CountWidth-1:0] HoldMsReset     = 16'd5000;

   // Multi-click window and the ceiling of the window timer.
   localparam logic [ClickWidth-1:0] ClickWindow = 11'd1000;
   localparam logic [ClickWidth-1:0] ClickSat    = 11'd2047;
   localparam logic [CountWidth-1:0] PressSat    = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'b001,
      PH_DEBOUNCE = 3'b010,
      PH_HELD     = 3'b100
   } phase_type;

   // Sticky poll marks.
   typedef struct packed {
      logic first_hold;
      logic long_press;
      logic pressed;
   } marks_type;

   // One result beat.
   typedef struct packed {
      logic                  held_now;
      logic                  press_event;
      logic                  hold_event;
      logic                  release_event;
      logic                  multi_click_event;
      marks_type             marks;
      logic [CountWidth-1:0] press_total;
      logic [CountWidth-1:0] click_total;
      logic [CountWidth-1:0] held_time;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/button_debounce_hold_multiclick.sv
// Push-button debouncer with long-press and multi-click detection. Each req_
// beat is one millisecond tick carrying the raw pin level and two poll
// acknowledges; each tick yields exactly one rsp_ beat. A press must persist
// for debounce_ms ticks to be confirmed; confirmed presses are counted in
// total and within a 1000-tick multi-click window, and from the second click
// in a window a multi-click pulse is given. While held, a hold event fires
// every hold_ms ticks, adding the elapsed ticks to held_time. The pressed and
// long-press marks are sticky and are cleared by ack_press and ack_long after
// the tick that reports them. The whole state update is a single pass of
// compare and add logic from the state registers into the result register,
// so a new beat is taken every cycle as long as the result register is empty
// or being drained in the same cycle. An accepted req_ beat gives its rsp_
// beat in the next cycle. Configuration writes on the csr_ port are always
// taken and must only be issued while idle.

`default_nettype none

module button_debounce_hold_multiclick (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Tick input channel
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic                                   req_button_level,
   input  wire logic                                   req_ack_press,
   input  wire logic                                   req_ack_long,
   // Result channel
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic                                   rsp_held_now,
   output      logic                                   rsp_press_event,
   output      logic                                   rsp_hold_event,
   output      logic                                   rsp_release_event,
   output      logic                                   rsp_multi_click_event,
   output      logic                                   rsp_pressed_flag,
   output      logic                                   rsp_long_flag,
   output      logic                                   rsp_first_hold_flag,
   output      logic [bdhm_pkg::CountWidth-1:0]        rsp_press_total,
   output      logic [bdhm_pkg::CountWidth-1:0]        rsp_click_total,
   output      logic [bdhm_pkg::CountWidth-1:0]        rsp_held_time,
   // Configuration write channel
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [bdhm_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire logic [bdhm_pkg::CsrDataWidth-1:0]      csr_wdata
);

   localparam int unsigned CW = bdhm_pkg::CountWidth;
   localparam int unsigned KW = bdhm_pkg::ClickWidth;

   // Configuration registers.
   logic          active_low_ff;
   logic [CW-1:0] debounce_ms_ff;
   logic [CW-1:0] hold_ms_ff;

   // Tick state.
   bdhm_pkg::phase_type phase_ff,         phase_in;
   logic [CW-1:0]       press_elapsed_ff, press_elapsed_in;
   logic [KW-1:0]       click_elapsed_ff, click_elapsed_in;
   logic [CW-1:0]       press_count_ff,   press_count_in;
   logic [CW-1:0]       click_count_ff,   click_count_in;
   logic [CW-1:0]       hold_accum_ff,    hold_accum_in;
   bdhm_pkg::marks_type marks_ff,         marks_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   bdhm_pkg::result_type result_ff,    result_in;

   logic                 req_accept;
   logic                 pressed;
   logic [CW-1:0]        press_elapsed_inc;
   logic [KW-1:0]        click_elapsed_inc;
   bdhm_pkg::marks_type  marks_step;
   logic                 ev_press;
   logic                 ev_hold;
   logic                 ev_release;
   logic                 ev_multi;

   // The result register takes a new beat whenever it is empty or its
   // current beat leaves in the same cycle, so ticks flow back to back.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff  <= bdhm_pkg::ActiveLowReset;
         debounce_ms_ff <= bdhm_pkg::DebounceMsReset;
         hold_ms_ff     <= bdhm_pkg::HoldMsReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdhm_pkg::CsrActiveLow:  active_low_ff  <= csr_wdata[0];
            bdhm_pkg::CsrDebounceMs: debounce_ms_ff <= csr_wdata[CW-1:0];
            bdhm_pkg::CsrHoldMs:     hold_ms_ff     <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // Polarity: in pull-up wiring a pressed button reads as a low level.
   assign pressed = active_low_ff ? !req_button_level : req_button_level;

   // Both timers advance at the start of every tick and saturate.
   assign press_elapsed_inc = (press_elapsed_ff == bdhm_pkg::PressSat) ?
                              press_elapsed_ff : press_elapsed_ff + CW'(1);
   assign click_elapsed_inc = (click_elapsed_ff == bdhm_pkg::ClickSat) ?
                              click_elapsed_ff : click_elapsed_ff + KW'(1);

   always_comb begin
      phase_in         = phase_ff;
      press_elapsed_in = press_elapsed_inc;
      click_elapsed_in = click_elapsed_inc;
      press_count_in   = press_count_ff;
      click_count_in   = click_count_ff;
      hold_accum_in    = hold_accum_ff;
      marks_step       = marks_ff;
      ev_press         = 1'b0;
      ev_hold          = 1'b0;
      ev_release       = 1'b0;
      ev_multi         = 1'b0;

      case (phase_ff)
         bdhm_pkg::PH_IDLE: begin
            // The multi-click window closes only while the button is up.
            if (click_count_ff != '0 && click_elapsed_inc >= bdhm_pkg::ClickWindow) begin
               click_count_in = '0;
            end
            if (pressed) begin
               press_elapsed_in = '0;
               phase_in         = bdhm_pkg::PH_DEBOUNCE;
            end
         end
         bdhm_pkg::PH_DEBOUNCE: begin
            if (press_elapsed_inc >= debounce_ms_ff) begin
               if (pressed) begin
                  hold_accum_in         = '0;
                  marks_step.long_press = 1'b0;
                  marks_step.pressed    = 1'b1;
                  marks_step.first_hold = 1'b1;
                  // The first click of a series opens a new window.
                  if (click_count_ff == '0) begin
                     click_elapsed_in = '0;
                  end
                  press_count_in = press_count_ff + CW'(1);
                  click_count_in = click_count_ff + CW'(1);
                  ev_press       = 1'b1;
                  ev_multi       = (click_count_in != '0) && (click_count_in != CW'(1));
                  phase_in       = bdhm_pkg::PH_HELD;
               end else begin
                  // Released once the debounce time ran out: treated as noise.
                  phase_in = bdhm_pkg::PH_IDLE;
               end
            end
         end
         bdhm_pkg::PH_HELD: begin
            if (pressed) begin
               if (press_elapsed_inc >= hold_ms_ff) begin
                  hold_accum_in         = hold_accum_ff + press_elapsed_inc;
                  press_elapsed_in      = '0;
                  ev_hold               = 1'b1;
                  marks_step.first_hold = 1'b0;
                  marks_step.long_press = 1'b1;
               end
            end else begin
               ev_release = 1'b1;
               phase_in   = bdhm_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = bdhm_pkg::PH_IDLE;
         end
      endcase

      // The acknowledges clear the marks only after they have been reported.
      marks_in = marks_step;
      if (req_ack_press) begin
         marks_in.pressed = 1'b0;
      end
      if (req_ack_long) begin
         marks_in.long_press = 1'b0;
      end

      result_in.held_now          = (phase_in == bdhm_pkg::PH_HELD);
      result_in.press_event       = ev_press;
      result_in.hold_event        = ev_hold;
      result_in.release_event     = ev_release;
      result_in.multi_click_event = ev_multi;
      result_in.marks             = marks_step;
      result_in.press_total       = press_count_in;
      result_in.click_total       = click_count_in;
      result_in.held_time         = hold_accum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= bdhm_pkg::PH_IDLE;
         press_elapsed_ff <= '0;
         click_elapsed_ff <= '0;
         press_count_ff   <= '0;
         click_count_ff   <= '0;
         hold_accum_ff    <= '0;
         marks_ff         <= '0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         press_elapsed_ff <= press_elapsed_in;
         click_elapsed_ff <= click_elapsed_in;
         press_count_ff   <= press_count_in;
         click_count_ff   <= click_count_in;
         hold_accum_ff    <= hold_accum_in;
         marks_ff         <= marks_in;
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_held_now          = result_ff.held_now;
   assign rsp_press_event       = result_ff.press_event;
   assign rsp_hold_event        = result_ff.hold_event;
   assign rsp_release_event     = result_ff.release_event;
   assign rsp_multi_click_event = result_ff.multi_click_event;
   assign rsp_pressed_flag      = result_ff.marks.pressed;
   assign rsp_long_flag         = result_ff.marks.long_press;
   assign rsp_first_hold_flag   = result_ff.marks.first_hold;
   assign rsp_press_total       = result_ff.press_total;
   assign rsp_click_total       = result_ff.click_total;
   assign rsp_held_time         = result_ff.held_time;

   // A confirmed press always lands in the held phase with fresh marks.
   a_press_enters_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_event |->
         rsp_held_now && rsp_pressed_flag && rsp_first_hold_flag && !rsp_long_flag)
      else $error("press beat without held phase or fresh marks");

   // A multi-click can only come with a press confirmation.
   a_multi_needs_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_multi_click_event |-> rsp_press_event)
      else $error("multi-click beat without press");

   // Hold events need the button still held; releases leave the held phase.
   a_hold_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hold_event |-> rsp_held_now && rsp_long_flag && !rsp_release_event)
      else $error("hold beat outside held phase");

   // The state advances only on an accepted tick.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(phase_ff) && $stable(press_count_ff) && $stable(hold_accum_ff))
      else $error("tick state changed without an accepted beat");

   // The press counter moves by exactly one per confirmed press.
   a_press_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && ev_press |=> press_count_ff == $past(press_count_ff) + CW'(1))
      else $error("press count did not advance by one");

endmodule

`default_nettype wire
